// ===== src/lkc_pkg.sv =====
package lkc_pkg;

	localparam int ENTRIES = 16;
	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;
	localparam int CAP_W   = 5;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int RANK_W  = $clog2(ENTRIES);
	localparam int OCC_W   = $clog2(ENTRIES + 1);

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [RANK_W-1:0] rank_t;
	typedef logic [OCC_W-1:0]  occ_t;
	typedef logic [CAP_W-1:0]  cap_t;

	localparam cap_t CAP_RESET = cap_t'(16);
	localparam cap_t CAP_MAX   = cap_t'(ENTRIES);

	typedef enum logic {
		CMD_GET = 1'b0,
		CMD_PUT = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t                    cmd;
		logic signed [KEY_W-1:0] key;
		logic signed [VAL_W-1:0] value;
	} in_t;

	typedef struct packed {
		logic                    found;
		logic signed [VAL_W-1:0] read_value;
		logic                    evicted;
	} out_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic lookup;
		logic access;
		logic insert;
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic needs_insert;
	} stat_t;

endpackage

// ===== src/lru_key_value_cache.sv =====
// The done beat follows the LOOKUP (key compare) and ACCESS (update) states for a get or a put
// on a present key, and the LOOKUP, ACCESS and INSERT states for a put of a new key.
// A new start is taken in the done cycle; in the states before it the block is busy and takes
// no new command until the lookup/update sequence and the value RAM read are through.
// The receiver cannot stall: done is high for one cycle only.
// Reset (arst_n low, async): store empty, capacity 16, no clearing pass.
module lru_key_value_cache (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  lkc_pkg::in_t              item,
	output logic                      done,
	output lkc_pkg::out_t             result,
	input  logic                      cfg_we,
	input  logic [lkc_pkg::CAP_W-1:0] cfg_wdata
);

	lkc_pkg::ctl_t  ctl;
	lkc_pkg::stat_t stat;

	lkc_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.busy  (busy),
		.done  (done),
		.ctl   (ctl)
	);

	lkc_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.item     (item),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.stat     (stat),
		.result   (result)
	);

`ifndef SYNTHESIS
	// an accepted command keeps the block busy and holds off the result beat
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted command did not start a lookup");

	// only a put of an absent key can evict
	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.evicted && result.found))
		else $error("eviction reported on a hit");

	// read data only on a get hit
	a_read_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.found) |-> (result.read_value == '0))
		else $error("read value on a miss");

	// an insert never follows a hit
	a_insert_miss: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.insert |-> !result.found)
		else $error("insert on a hit");
`endif

endmodule

// ===== src/lkc_ram.sv =====
module lkc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AddrW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/lkc_ctrl.sv =====
module lkc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  lkc_pkg::stat_t stat,
	output logic          busy,
	output logic          done,
	output lkc_pkg::ctl_t ctl
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_LOOKUP = 5'b00010,
		S_ACCESS = 5'b00100,
		S_INSERT = 5'b01000,
		S_DONE   = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	// the result beat is shown in S_DONE, so a new command may land there
	assign busy   = !(state_q == S_IDLE || state_q == S_DONE);
	assign done   = (state_q == S_DONE);
	assign accept = start && !busy;

	assign ctl.capture = accept;
	assign ctl.lookup  = (state_q == S_LOOKUP);
	assign ctl.access  = (state_q == S_ACCESS);
	assign ctl.insert  = (state_q == S_INSERT);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   state_d = accept ? S_LOOKUP : S_IDLE;
			S_LOOKUP: state_d = S_ACCESS;
			S_ACCESS: state_d = stat.needs_insert ? S_INSERT : S_DONE;
			S_INSERT: state_d = S_DONE;
			S_DONE:   state_d = accept ? S_LOOKUP : S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== src/lkc_dpath.sv =====
module lkc_dpath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lkc_pkg::ctl_t                   ctl,
	input  lkc_pkg::in_t                    item,
	input  logic                            cfg_we,
	input  logic [lkc_pkg::CAP_W-1:0]       cfg_wdata,
	output lkc_pkg::stat_t                  stat,
	output lkc_pkg::out_t                   result
);

	// captured command
	lkc_pkg::cmd_t                   cmd_q;
	logic [lkc_pkg::KEY_W-1:0]       key_q;
	logic [lkc_pkg::VAL_W-1:0]       value_q;

	// store state
	logic                            valid_q [lkc_pkg::ENTRIES];
	logic [lkc_pkg::KEY_W-1:0]       key_mem_q [lkc_pkg::ENTRIES];
	lkc_pkg::rank_t                  rank_q [lkc_pkg::ENTRIES];
	lkc_pkg::occ_t                   occ_q;
	lkc_pkg::cap_t                   cap_q;

	// lookup results
	logic                            hit_q;
	lkc_pkg::idx_t                   hit_idx_q;
	lkc_pkg::rank_t                  hit_rank_q;
	logic                            need_evict_q;
	logic                            evicted_q;

	logic [lkc_pkg::ENTRIES-1:0]     match;
	logic [lkc_pkg::ENTRIES-1:0]     oldest;
	logic                            hit;
	lkc_pkg::idx_t                   hit_idx;
	lkc_pkg::idx_t                   free_idx;
	lkc_pkg::occ_t                   eff_cap;
	lkc_pkg::rank_t                  last_rank;
	logic                            is_put;
	logic                            ram_we;
	logic                            ram_re;
	lkc_pkg::idx_t                   ram_waddr;
	logic [lkc_pkg::VAL_W-1:0]       ram_rdata;

	assign is_put = (cmd_q == lkc_pkg::CMD_PUT);

	always_comb begin
		for (int i = 0; i < lkc_pkg::ENTRIES; i++) begin
			match[i] = valid_q[i] && (key_mem_q[i] == key_q);
		end
	end

	// lowest matching slot; keys are unique among valid slots anyway
	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int i = lkc_pkg::ENTRIES - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit     = 1'b1;
				hit_idx = lkc_pkg::idx_t'(i);
			end
		end
	end

	always_comb begin
		free_idx = '0;
		for (int i = lkc_pkg::ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = lkc_pkg::idx_t'(i);
			end
		end
	end

	always_comb begin
		if (cap_q == '0) begin
			eff_cap = lkc_pkg::occ_t'(1);
		end else if (cap_q > lkc_pkg::CAP_MAX) begin
			eff_cap = lkc_pkg::occ_t'(lkc_pkg::CAP_MAX);
		end else begin
			eff_cap = lkc_pkg::occ_t'(cap_q);
		end
	end

	// valid ranks are a permutation of 0..occ-1, so the LRU slot holds occ-1
	assign last_rank = lkc_pkg::rank_t'(occ_q - lkc_pkg::occ_t'(1));

	always_comb begin
		for (int i = 0; i < lkc_pkg::ENTRIES; i++) begin
			oldest[i] = valid_q[i] && (rank_q[i] == last_rank);
		end
	end

	assign stat.needs_insert = is_put && !hit_q;

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q   <= item.cmd;
			key_q   <= item.key;
			value_q <= item.value;
		end
		if (ctl.lookup) begin
			hit_idx_q  <= hit_idx;
			hit_rank_q <= rank_q[hit_idx];
		end
		if (ctl.insert) begin
			key_mem_q[free_idx] <= key_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lkc_pkg::ENTRIES; i++) begin
				valid_q[i] <= 1'b0;
				rank_q[i]  <= '0;
			end
			occ_q        <= '0;
			cap_q        <= lkc_pkg::CAP_RESET;
			hit_q        <= 1'b0;
			need_evict_q <= 1'b0;
			evicted_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (ctl.capture) begin
				evicted_q <= 1'b0;
			end
			if (ctl.lookup) begin
				hit_q        <= hit;
				need_evict_q <= (occ_q >= eff_cap) && (occ_q != '0);
			end
			if (ctl.access) begin
				if (hit_q) begin
					// touch: younger entries age by one, hit becomes most recent
					for (int i = 0; i < lkc_pkg::ENTRIES; i++) begin
						if (lkc_pkg::idx_t'(i) == hit_idx_q) begin
							rank_q[i] <= '0;
						end else if (valid_q[i] && rank_q[i] < hit_rank_q) begin
							rank_q[i] <= rank_q[i] + lkc_pkg::rank_t'(1);
						end
					end
				end else if (is_put && need_evict_q) begin
					for (int i = 0; i < lkc_pkg::ENTRIES; i++) begin
						if (oldest[i]) begin
							valid_q[i] <= 1'b0;
							rank_q[i]  <= '0;
						end
					end
					occ_q     <= occ_q - lkc_pkg::occ_t'(1);
					evicted_q <= 1'b1;
				end
			end
			if (ctl.insert) begin
				for (int i = 0; i < lkc_pkg::ENTRIES; i++) begin
					if (lkc_pkg::idx_t'(i) == free_idx) begin
						valid_q[i] <= 1'b1;
						rank_q[i]  <= '0;
					end else if (valid_q[i]) begin
						rank_q[i] <= rank_q[i] + lkc_pkg::rank_t'(1);
					end
				end
				occ_q <= occ_q + lkc_pkg::occ_t'(1);
			end
		end
	end

	assign ram_we    = (ctl.access && is_put && hit_q) || ctl.insert;
	assign ram_waddr = ctl.insert ? free_idx : hit_idx_q;
	assign ram_re    = ctl.access && !is_put && hit_q;

	lkc_ram #(
		.WIDTH(lkc_pkg::VAL_W),
		.DEPTH(lkc_pkg::ENTRIES)
	) u_value_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(value_q),
		.re   (ram_re),
		.raddr(hit_idx_q),
		.rdata(ram_rdata)
	);

	assign result.found      = hit_q;
	assign result.read_value = (hit_q && !is_put) ? ram_rdata : '0;
	assign result.evicted    = evicted_q;

endmodule
